// ----- rtl/keyboard_report_to_text_cursor_defines.svh -----
// Assertion macros used by the keyboard report to text cursor RTL.
// Each macro expects clk and rst_n in scope.
`ifndef KEYBOARD_REPORT_TO_TEXT_CURSOR_DEFINES_SVH
`define KEYBOARD_REPORT_TO_TEXT_CURSOR_DEFINES_SVH

// Same-cycle implication
`define KBTC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define KBTC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/kbtc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package kbtc_pkg;

  // Field widths
  localparam int KEY_W = 8;
  localparam int COL_W = 6;
  localparam int ROW_W = 5;
  localparam int CNT_W = 11;
  localparam int SCR_W = 2;

  // Screen and store geometry
  localparam int TEXT_CAPACITY = 1024;
  localparam int SCREEN_COLS   = 64;
  localparam int SCREEN_ROWS   = 24;
  localparam int BOX_ROWS      = 2;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [ROW_W-1:0] FIRST_ROW = ROW_W'(SCREEN_ROWS - BOX_ROWS);
  localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(SCREEN_ROWS - 1);
  localparam logic [COL_W-1:0] LAST_COL  = COL_W'(SCREEN_COLS - 1);
  localparam logic [CNT_W-1:0] CAP_CNT   = CNT_W'(TEXT_CAPACITY);
  localparam logic [CNT_W-1:0] UPPER_CNT = CNT_W'(SCREEN_COLS * (BOX_ROWS - 1));

  // Keycodes
  localparam logic [KEY_W-1:0] KEY_BACKSPACE = 8'h2a;
  localparam logic [KEY_W-1:0] MAP_LOW       = 8'd4;
  localparam logic [KEY_W-1:0] MAP_HIGH      = 8'd29;
  localparam logic [KEY_W-1:0] MAP_OFFSET    = 8'd93;

  // Result codes
  localparam logic             ACT_TYPE  = 1'b0;
  localparam logic             ACT_ERASE = 1'b1;
  localparam logic [SCR_W-1:0] SCR_NONE  = 2'd0;
  localparam logic [SCR_W-1:0] SCR_DOWN  = 2'd1;
  localparam logic [SCR_W-1:0] SCR_UP    = 2'd2;

  // Work for one report, front to back
  typedef struct packed {
    logic             bs;
    logic             t1;
    logic [KEY_W-1:0] ch1;
    logic             t2;
    logic [KEY_W-1:0] ch2;
  } cmd_t;

  // One result item
  typedef struct packed {
    logic             action;
    logic [KEY_W-1:0] char_code;
    logic [COL_W-1:0] pos_col;
    logic [ROW_W-1:0] pos_row;
    logic [COL_W-1:0] next_col;
    logic [ROW_W-1:0] next_row;
    logic [SCR_W-1:0] scrolled;
    logic [CNT_W-1:0] stored_count;
    logic             dropped;
    logic             last;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/kbtc_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface kbtc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] modifiers;
  logic [7:0] key_first;
  logic [7:0] key_second;

  modport source (output valid, modifiers, key_first, key_second, input ready);
  modport sink (input valid, modifiers, key_first, key_second, output ready);
endinterface

`default_nettype wire

// ----- rtl/kbtc_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface kbtc_out_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [7:0]  char_code;
  logic [5:0]  pos_col;
  logic [4:0]  pos_row;
  logic [5:0]  next_col;
  logic [4:0]  next_row;
  logic [1:0]  scrolled;
  logic [10:0] stored_count;
  logic        dropped;
  logic        last;

  modport source (output valid, action, char_code, pos_col, pos_row, next_col,
                  next_row, scrolled, stored_count, dropped, last, input ready);
  modport sink (input valid, action, char_code, pos_col, pos_row, next_col,
                next_row, scrolled, stored_count, dropped, last, output ready);
endinterface

`default_nettype wire

// ----- rtl/kbtc_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module kbtc_front (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [kbtc_pkg::KEY_W-1:0] in_modifiers,
  input  wire logic [kbtc_pkg::KEY_W-1:0] in_key_first,
  input  wire logic [kbtc_pkg::KEY_W-1:0] in_key_second,
  input  wire logic                    q_full,
  output logic                         q_push,
  output kbtc_pkg::cmd_t               q_cmd
);
  import kbtc_pkg::*;

  logic [KEY_W-1:0] held_r, held_nxt;
  logic [KEY_W-1:0] deb_r, deb_nxt;
  logic [KEY_W-1:0] carry_r, carry_nxt;
  logic             single_r, single_nxt;
  logic [KEY_W-1:0] k1, k2;
  logic             two;
  logic             fire;
  cmd_t             cmd;

  function automatic logic [KEY_W-1:0] map_key(input logic [KEY_W-1:0] c);
    logic [KEY_W-1:0] m;
    m = c;
    if (c >= MAP_LOW && c <= MAP_HIGH) begin
      m = c + MAP_OFFSET;
    end
    return m;
  endfunction

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;
  assign k1       = map_key(in_key_first);
  assign k2       = map_key(in_key_second);
  assign two      = (in_key_second != '0);

  // Classify the report and update repeat tracking
  always_comb begin
    held_nxt   = held_r;
    deb_nxt    = deb_r;
    carry_nxt  = carry_r;
    single_nxt = single_r;
    cmd        = '0;
    if (in_key_first == KEY_BACKSPACE) begin
      held_nxt   = '0;
      deb_nxt    = '0;
      carry_nxt  = '0;
      single_nxt = 1'b0;
      cmd.bs     = 1'b1;
    end else if (in_modifiers == '0 && in_key_first == '0 && in_key_second == '0) begin
      held_nxt   = '0;
      deb_nxt    = '0;
      carry_nxt  = '0;
      single_nxt = 1'b0;
    end else begin
      if ((single_r || deb_r == '0) && (!two || held_r != k1) && carry_r != k1) begin
        cmd.t1    = 1'b1;
        cmd.ch1   = k1;
        held_nxt  = k1;
        carry_nxt = '0;
        if (!two) begin
          single_nxt = 1'b1;
        end
      end else if (!two && deb_r != '0 && carry_r == k1) begin
        single_nxt = 1'b1;
        carry_nxt  = '0;
      end
      // carry_nxt already reflects the first key's effect
      if (two && carry_nxt != k2) begin
        cmd.t2     = 1'b1;
        cmd.ch2    = k2;
        deb_nxt    = k2;
        held_nxt   = '0;
        carry_nxt  = k2;
        single_nxt = 1'b0;
      end
    end
  end

  assign q_push = fire && (cmd.bs || cmd.t1 || cmd.t2);
  assign q_cmd  = cmd;

  // Tracking registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r   <= '0;
      deb_r    <= '0;
      carry_r  <= '0;
      single_r <= 1'b0;
    end else if (fire) begin
      held_r   <= held_nxt;
      deb_r    <= deb_nxt;
      carry_r  <= carry_nxt;
      single_r <= single_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/kbtc_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module kbtc_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire kbtc_pkg::cmd_t push_cmd,
  output logic                full,
  output logic                not_empty,
  output kbtc_pkg::cmd_t      head_cmd,
  input  wire logic           pop
);
  import kbtc_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(QUEUE_DEPTH);

  cmd_t              mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [FILL_W-1:0] fill_r;

  assign full      = (fill_r == FILL_MAX);
  assign not_empty = (fill_r != '0);
  assign head_cmd  = mem[rd_ptr_r];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/kbtc_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "keyboard_report_to_text_cursor_defines.svh"

module kbtc_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid,
  input  wire kbtc_pkg::cmd_t q_cmd,
  output logic                q_pop,
  output logic                out_vld,
  input  wire logic           out_rdy,
  output kbtc_pkg::res_t      out_res
);
  import kbtc_pkg::*;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] line_r, line_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             second_r;
  logic             out_vld_r;
  res_t             out_res_r, res;
  logic             go, skip, last_type, emit;
  logic [KEY_W-1:0] cur_ch;

  assign go        = q_valid && (!out_vld_r || out_rdy);
  assign skip      = (col_r == '0) && (line_r <= FIRST_ROW) && (count_r == '0);
  assign cur_ch    = (second_r || !q_cmd.t1) ? q_cmd.ch2 : q_cmd.ch1;
  assign last_type = second_r || !(q_cmd.t1 && q_cmd.t2);

  // Cursor step for the command at the head of the queue
  always_comb begin
    col_nxt   = col_r;
    line_nxt  = line_r;
    count_nxt = count_r;
    res       = '0;
    if (q_cmd.bs) begin
      res.scrolled = SCR_NONE;
      if (col_r == '0) begin
        col_nxt = LAST_COL;
        if (line_r >= LAST_ROW) begin
          if (count_r <= UPPER_CNT) begin
            line_nxt = LAST_ROW - 1'b1;
          end else begin
            res.scrolled = SCR_UP;
          end
        end else if (line_r > FIRST_ROW) begin
          line_nxt = line_r - 1'b1;
        end else begin
          res.scrolled = SCR_UP;
        end
      end else begin
        col_nxt = col_r - 1'b1;
      end
      if (count_r != '0) begin
        count_nxt = count_r - 1'b1;
      end
      res.action    = ACT_ERASE;
      res.char_code = '0;
      res.pos_col   = col_nxt;
      res.pos_row   = line_nxt;
      res.dropped   = 1'b0;
      res.last      = 1'b1;
    end else begin
      res.scrolled = SCR_NONE;
      res.dropped  = 1'b0;
      if (count_r >= CAP_CNT) begin
        res.dropped = 1'b1;
      end else begin
        count_nxt = count_r + 1'b1;
        if (col_r >= LAST_COL) begin
          col_nxt = '0;
          if (line_r < LAST_ROW) begin
            line_nxt = line_r + 1'b1;
          end else begin
            res.scrolled = SCR_DOWN;
          end
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      res.action    = ACT_TYPE;
      res.char_code = cur_ch;
      res.pos_col   = col_r;
      res.pos_row   = line_r;
      res.last      = last_type;
    end
    res.next_col     = col_nxt;
    res.next_row     = line_nxt;
    res.stored_count = count_nxt;
  end

  assign emit  = go && !(q_cmd.bs && skip);
  assign q_pop = go && (q_cmd.bs || last_type);

  // Cursor, count and sub-step state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      line_r   <= FIRST_ROW;
      count_r  <= '0;
      second_r <= 1'b0;
    end else if (go) begin
      if (emit) begin
        col_r   <= col_nxt;
        line_r  <= line_nxt;
        count_r <= count_nxt;
      end
      second_r <= !q_cmd.bs && !last_type;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (emit) begin
      out_vld_r <= 1'b1;
    end else if (out_rdy) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_res_r <= res;
    end
  end

  assign out_vld = out_vld_r;
  assign out_res = out_res_r;

  `KBTC_ASSERT_IMP(a_row_in_box, 1'b1, (line_r >= FIRST_ROW) && (line_r <= LAST_ROW), "cursor row left the text box")
  `KBTC_ASSERT_IMP(a_count_cap, 1'b1, count_r <= CAP_CNT, "stored count above capacity")
  `KBTC_ASSERT_IMP(a_second_entry, second_r, q_valid && q_cmd.t1 && q_cmd.t2 && !q_cmd.bs, "second key step without a two-key entry")
  `KBTC_ASSERT_NXT(a_second_follows, go && !q_cmd.bs && q_cmd.t1 && q_cmd.t2 && !second_r, second_r, "two-key entry did not move to its second step")

endmodule

`default_nettype wire

// ----- rtl/keyboard_report_to_text_cursor.sv -----
// Keyboard report to text cursor.
// in_ch carries one two-key keyboard report per item (modifiers, key_first,
// key_second); out_ch carries zero, one or two results per report, each a
// typed or erased character with its position, the new cursor, scroll
// status, stored count and a last flag on the report's final result.
// Both channels are valid/ready; an item moves when both are high.
// Path: a report accepted on in_ch is written into the queue, and its first
// result is then registered in the output register; a second result follows.
// Throughput: one report per cycle while each yields at most one result and
// out_ch does not stall; a report that types two keys holds the cursor unit
// for both its results. The cursor unit updates one result per cycle while
// out_ch is ready and sets the rate. A two-entry queue separates report
// classification from the cursor unit, so in_ch keeps accepting while a
// result waits in the output register. When out_ch stalls, the output
// register holds, the queue fills and in_ready drops once it is full;
// nothing is lost. Reset (synchronous, active low) clears repeat tracking,
// empties the queue, puts the cursor at column 0 of the first box row, count 0.
`timescale 1ns / 1ps
`default_nettype none

module keyboard_report_to_text_cursor (
  input  wire logic clk,
  input  wire logic rst_n,
  kbtc_in_if.sink   in_ch,
  kbtc_out_if.source out_ch
);
  import kbtc_pkg::*;

  logic q_full, q_push, q_not_empty, q_pop;
  cmd_t push_cmd, head_cmd;
  res_t res;
  logic out_vld;

  kbtc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_modifiers  (in_ch.modifiers),
    .in_key_first  (in_ch.key_first),
    .in_key_second (in_ch.key_second),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (push_cmd)
  );

  kbtc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_cmd  (head_cmd),
    .pop       (q_pop)
  );

  kbtc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_not_empty),
    .q_cmd   (head_cmd),
    .q_pop   (q_pop),
    .out_vld (out_vld),
    .out_rdy (out_ch.ready),
    .out_res (res)
  );

  assign out_ch.valid        = out_vld;
  assign out_ch.action       = res.action;
  assign out_ch.char_code    = res.char_code;
  assign out_ch.pos_col      = res.pos_col;
  assign out_ch.pos_row      = res.pos_row;
  assign out_ch.next_col     = res.next_col;
  assign out_ch.next_row     = res.next_row;
  assign out_ch.scrolled     = res.scrolled;
  assign out_ch.stored_count = res.stored_count;
  assign out_ch.dropped      = res.dropped;
  assign out_ch.last         = res.last;

endmodule

`default_nettype wire
